// File: sv/allgather_schedule_generator_core_macros.svh
// Assertion macros used by the checker file of the allgather schedule generator.
`ifndef ALLGATHER_SCHEDULE_GENERATOR_CORE_MACROS_SVH
`define ALLGATHER_SCHEDULE_GENERATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AGS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("allgather schedule generator: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AGS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("allgather schedule generator: assertion failed");

`endif

// File: sv/ags_pkg.sv
`timescale 1ns / 1ps

package ags_pkg;

	// Field widths.
	localparam int RankW  = 6;
	localparam int SizeW  = 7;
	localparam int ElemW  = 20;
	localparam int EbW    = 9;
	localparam int CntW   = 27;
	localparam int CfgW   = 35;
	localparam int TotalW = 36;
	localparam int StepW  = 6;
	localparam int LgW    = 3;
	localparam int AlgW   = 2;
	localparam int CfgIdxW = 1;

	// Largest group that produces a schedule.
	localparam logic [SizeW-1:0] MaxRanks = 7'd64;

	// Algorithm codes as shown on the output.
	localparam logic [AlgW-1:0] AlgRd    = 2'd0;
	localparam logic [AlgW-1:0] AlgBruck = 2'd1;
	localparam logic [AlgW-1:0] AlgRing  = 2'd2;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] CfgLong  = 1'd0;
	localparam logic [CfgIdxW-1:0] CfgShort = 1'd1;

	// Configuration reset values.
	localparam logic [CfgW-1:0] LongReset  = 35'd524288;
	localparam logic [CfgW-1:0] ShortReset = 35'd81920;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_req;
		logic mul1;
		logic mul2;
		logic decide;
		logic emit;
	} ags_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic no_steps;
		logic last;
		logic out_free;
	} ags_sts_t;

endpackage

// File: sv/ags_ctrl.sv
`timescale 1ns / 1ps

module ags_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  ags_pkg::ags_sts_t sts,
	output ags_pkg::ags_cmd_t cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_MUL1   = 3'd1;
	localparam logic [2:0] S_MUL2   = 3'd2;
	localparam logic [2:0] S_DECIDE = 3'd3;
	localparam logic [2:0] S_RUN    = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// A request is taken only while no schedule is being built.
	assign in_stall = (state_q != S_IDLE);

	// Commands follow from the state, gated by in_valid and out_free.
	always_comb begin
		cmd.load_req = (state_q == S_IDLE) && in_valid;
		cmd.mul1     = (state_q == S_MUL1);
		cmd.mul2     = (state_q == S_MUL2);
		cmd.decide   = (state_q == S_DECIDE);
		cmd.emit     = (state_q == S_RUN) && sts.out_free;
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_MUL1;
			end
			S_MUL1:   state_d = S_MUL2;
			S_MUL2:   state_d = S_DECIDE;
			S_DECIDE: begin
				state_d = sts.no_steps ? S_IDLE : S_RUN;
			end
			S_RUN: begin
				if (sts.out_free && sts.last) state_d = S_IDLE;
			end
			default:  state_d = S_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: sv/ags_dp.sv
`timescale 1ns / 1ps

module ags_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ags_pkg::ags_cmd_t             cmd,
	output ags_pkg::ags_sts_t             sts,
	input  logic                          cfg_we,
	input  logic [ags_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [ags_pkg::CfgW-1:0]      cfg_data,
	input  logic [ags_pkg::RankW-1:0]     own_rank,
	input  logic [ags_pkg::SizeW-1:0]     group_size,
	input  logic [ags_pkg::ElemW-1:0]     send_elems,
	input  logic [ags_pkg::ElemW-1:0]     recv_elems,
	input  logic [ags_pkg::EbW-1:0]       elem_bytes,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ags_pkg::RankW-1:0]     dest_rank,
	output logic [ags_pkg::RankW-1:0]     source_rank,
	output logic [ags_pkg::CntW-1:0]      step_send_elems,
	output logic [ags_pkg::CntW-1:0]      step_recv_elems,
	output logic [ags_pkg::AlgW-1:0]      algorithm,
	output logic                          last_step
);

	// Configuration registers.
	logic [ags_pkg::CfgW-1:0] long_q;
	logic [ags_pkg::CfgW-1:0] short_q;

	// Request registers.
	logic [ags_pkg::RankW-1:0] rank_q;
	logic [ags_pkg::SizeW-1:0] p_q;
	logic [ags_pkg::ElemW-1:0] r_q;
	logic [ags_pkg::EbW-1:0]   eb_q;
	logic                      rej_q;

	// Byte total pipeline and schedule plan.
	logic [ags_pkg::CntW-1:0]   prod1_q;
	logic [ags_pkg::TotalW-1:0] total_q;
	logic [ags_pkg::AlgW-1:0]   alg_q;
	logic [ags_pkg::LgW-1:0]    lg_q;
	logic [ags_pkg::StepW-1:0]  nsteps_q;
	logic [ags_pkg::StepW-1:0]  idx_q;

	// Output register.
	logic                      out_valid_q;
	logic [ags_pkg::RankW-1:0] dst_q;
	logic [ags_pkg::RankW-1:0] src_q;
	logic [ags_pkg::CntW-1:0]  scnt_q;
	logic [ags_pkg::CntW-1:0]  rcnt_q;
	logic [ags_pkg::AlgW-1:0]  oalg_q;
	logic                      last_q;

	// Plan logic.
	logic                      pow2;
	logic [ags_pkg::LgW-1:0]   lg_d;
	logic                      use_rd;
	logic                      use_br;
	logic [ags_pkg::AlgW-1:0]  alg_d;
	logic [ags_pkg::StepW-1:0] nsteps_d;

	// Step logic.
	logic [ags_pkg::SizeW-1:0] pof2;
	logic [ags_pkg::SizeW-1:0] lowmask;
	logic [ags_pkg::RankW-1:0] rd_dst;
	logic [ags_pkg::RankW-1:0] rd_root;
	logic [ags_pkg::SizeW-1:0] rd_a;
	logic [ags_pkg::SizeW-1:0] br_sum;
	logic [ags_pkg::SizeW-1:0] br_src;
	logic [ags_pkg::SizeW-1:0] br_dsum;
	logic [ags_pkg::SizeW-1:0] br_dst;
	logic [ags_pkg::SizeW-1:0] br_a;
	logic                      br_rem;
	logic [ags_pkg::RankW-1:0] ring_right;
	logic [ags_pkg::RankW-1:0] ring_left;
	logic [ags_pkg::SizeW-1:0] mul_a;
	logic [ags_pkg::CntW-1:0]  step_prod;
	logic [ags_pkg::CntW-1:0]  shifted;
	logic [ags_pkg::RankW-1:0] dst_d;
	logic [ags_pkg::RankW-1:0] src_d;
	logic [ags_pkg::CntW-1:0]  scnt_d;
	logic [ags_pkg::CntW-1:0]  rcnt_d;
	logic                      is_last;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_q  <= ags_pkg::LongReset;
			short_q <= ags_pkg::ShortReset;
		end else if (cfg_we) begin
			case (cfg_index)
				ags_pkg::CfgLong:  long_q  <= cfg_data;
				ags_pkg::CfgShort: short_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Capture the request; a zero send count, a rank outside the group or a too large group is flagged here.
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			rank_q <= own_rank;
			p_q    <= group_size;
			r_q    <= recv_elems;
			eb_q   <= elem_bytes;
			rej_q  <= (send_elems == '0) || ({1'b0, own_rank} >= group_size) ||
			          (group_size > ags_pkg::MaxRanks);
		end
	end

	// Byte total in two multiply stages: recv_elems * group_size, then * elem_bytes.
	always_ff @(posedge clk) begin
		if (cmd.mul1) begin
			prod1_q <= {7'b0, r_q} * {20'b0, p_q};
		end
		if (cmd.mul2) begin
			total_q <= {9'b0, prod1_q} * {27'b0, eb_q};
		end
	end

	// Floor of log2 of the group size.
	always_comb begin
		lg_d = '0;
		for (int b = 0; b < ags_pkg::SizeW; b++) begin
			if (p_q[b]) lg_d = ags_pkg::LgW'(b);
		end
	end

	// Scheme choice and number of steps.
	always_comb begin
		pow2   = ((p_q & (p_q - 7'd1)) == '0);
		use_rd = (total_q < {1'b0, long_q}) && pow2;
		use_br = !use_rd && (total_q < {1'b0, short_q});
		if (use_rd) begin
			alg_d    = ags_pkg::AlgRd;
			nsteps_d = {3'b0, lg_d};
		end else if (use_br) begin
			alg_d    = ags_pkg::AlgBruck;
			nsteps_d = {3'b0, lg_d} + {5'b0, !pow2};
		end else begin
			alg_d    = ags_pkg::AlgRing;
			nsteps_d = ags_pkg::StepW'(p_q - 7'd1);
		end
		if (rej_q) nsteps_d = '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			alg_q    <= alg_d;
			lg_q     <= lg_d;
			nsteps_q <= nsteps_d;
		end
	end

	// Step counter.
	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			idx_q <= '0;
		end else if (cmd.emit) begin
			idx_q <= idx_q + 6'd1;
		end
	end

	// Partners and counts of the current step.
	always_comb begin
		pof2    = 7'd1 << idx_q[2:0];
		lowmask = pof2 - 7'd1;
		// Recursive doubling: partner is rank XOR mask, receive covers its subtree.
		rd_dst  = rank_q ^ pof2[5:0];
		rd_root = rd_dst & ~lowmask[5:0];
		rd_a    = p_q - {1'b0, rd_root};
		// Bruck: partners at distance pof2, both taken modulo the group size.
		br_sum  = {1'b0, rank_q} + pof2;
		br_src  = (br_sum >= p_q) ? (br_sum - p_q) : br_sum;
		br_dsum = {1'b0, rank_q} + p_q - pof2;
		br_dst  = (br_dsum >= p_q) ? (br_dsum - p_q) : br_dsum;
		br_a    = p_q - pof2;
		br_rem  = (idx_q == {3'b0, lg_q});
		// Ring neighbors.
		ring_right = ({1'b0, rank_q} == p_q - 7'd1) ? '0 : rank_q + 6'd1;
		ring_left  = (rank_q == '0) ? ags_pkg::RankW'(p_q - 7'd1) : rank_q - 6'd1;
		mul_a      = (alg_q == ags_pkg::AlgRd) ? rd_a : br_a;
		step_prod  = {7'b0, r_q} * {20'b0, mul_a};
		shifted    = {7'b0, r_q} << idx_q[2:0];
		is_last    = (idx_q == nsteps_q - 6'd1);
		case (alg_q)
			ags_pkg::AlgRd: begin
				dst_d  = rd_dst;
				src_d  = rd_dst;
				scnt_d = shifted;
				rcnt_d = step_prod;
			end
			ags_pkg::AlgBruck: begin
				dst_d  = br_dst[5:0];
				src_d  = br_src[5:0];
				scnt_d = br_rem ? step_prod : shifted;
				rcnt_d = br_rem ? step_prod : shifted;
			end
			default: begin
				dst_d  = ring_right;
				src_d  = ring_left;
				scnt_d = {7'b0, r_q};
				rcnt_d = {7'b0, r_q};
			end
		endcase
	end

	// Output register: loads a step when empty or when the held step transfers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			dst_q  <= dst_d;
			src_q  <= src_d;
			scnt_q <= scnt_d;
			rcnt_q <= rcnt_d;
			oalg_q <= alg_q;
			last_q <= is_last;
		end
	end

	// Status to the controller.
	always_comb begin
		sts.no_steps = (nsteps_d == '0);
		sts.last     = is_last;
		sts.out_free = !out_valid_q || !out_stall;
	end

	assign out_valid       = out_valid_q;
	assign dest_rank       = dst_q;
	assign source_rank     = src_q;
	assign step_send_elems = scnt_q;
	assign step_recv_elems = rcnt_q;
	assign algorithm       = oalg_q;
	assign last_step       = last_q;

endmodule

// File: sv/allgather_schedule_generator_core.sv
`timescale 1ns / 1ps

// Allgather schedule generator: each request is turned into its list of paired send/receive
// steps (recursive doubling, Bruck with a remainder step, or ring), one step per transfer,
// the final one flagged by last_step. A request is captured in IDLE, its byte total is formed
// in two multiply stages (MUL1, MUL2) and the scheme is picked in DECIDE; then the steps come
// out while the output is not stalled, and a request with no steps goes back to IDLE.
// The rate is set by the step sequencer, which builds one step per cycle while the output is
// not stalled, through a single shared count multiplier, and handles one request at a time.
module allgather_schedule_generator_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [ags_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [ags_pkg::CfgW-1:0]    cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [ags_pkg::RankW-1:0]   own_rank,
	input  logic [ags_pkg::SizeW-1:0]   group_size,
	input  logic [ags_pkg::ElemW-1:0]   send_elems,
	input  logic [ags_pkg::ElemW-1:0]   recv_elems,
	input  logic [ags_pkg::EbW-1:0]     elem_bytes,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [ags_pkg::RankW-1:0]   dest_rank,
	output logic [ags_pkg::RankW-1:0]   source_rank,
	output logic [ags_pkg::CntW-1:0]    step_send_elems,
	output logic [ags_pkg::CntW-1:0]    step_recv_elems,
	output logic [ags_pkg::AlgW-1:0]    algorithm,
	output logic                        last_step
);

	ags_pkg::ags_cmd_t cmd;
	ags_pkg::ags_sts_t sts;

	// Sequencing of one request.
	ags_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Registers, arithmetic and output stage.
	ags_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.own_rank        (own_rank),
		.group_size      (group_size),
		.send_elems      (send_elems),
		.recv_elems      (recv_elems),
		.elem_bytes      (elem_bytes),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.dest_rank       (dest_rank),
		.source_rank     (source_rank),
		.step_send_elems (step_send_elems),
		.step_recv_elems (step_recv_elems),
		.algorithm       (algorithm),
		.last_step       (last_step)
	);

endmodule

// File: sv/ags_checker.sv
`timescale 1ns / 1ps
`include "allgather_schedule_generator_core_macros.svh"

module ags_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic [ags_pkg::RankW-1:0] dest_rank,
	input  logic [ags_pkg::RankW-1:0] source_rank,
	input  logic [ags_pkg::CntW-1:0]  step_send_elems,
	input  logic [ags_pkg::CntW-1:0]  step_recv_elems,
	input  logic [ags_pkg::AlgW-1:0]  algorithm,
	input  logic                      last_step
);

	// A stalled step stays offered.
	`AGS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)

	// A stalled step keeps its payload.
	`AGS_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(dest_rank) && $stable(source_rank) && $stable(step_send_elems) && $stable(step_recv_elems) && $stable(algorithm) && $stable(last_step))

	// After a request transfers, the block is busy with its schedule.
	`AGS_ASSERT_NEXT(a_busy_after_req, clk, arst_n, in_valid && !in_stall, in_stall)

	// A schedule runs without gaps and under one scheme until its last step.
	`AGS_ASSERT_NEXT(a_no_gap, clk, arst_n, out_valid && !out_stall && !last_step, out_valid && $stable(algorithm))

endmodule

bind allgather_schedule_generator_core ags_checker u_ags_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.dest_rank       (dest_rank),
	.source_rank     (source_rank),
	.step_send_elems (step_send_elems),
	.step_recv_elems (step_recv_elems),
	.algorithm       (algorithm),
	.last_step       (last_step)
);

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int WatchdogLimit = 4000;
	localparam int IdlePad       = 10;
	localparam int HoldCycles    = 400;
	localparam int ItemTarget    = 380;
	localparam int NumPhases     = 6;

	// One step of an allgather schedule as seen on the output.
	typedef struct packed {
		logic [ags_pkg::RankW-1:0] dest;
		logic [ags_pkg::RankW-1:0] source;
		logic [ags_pkg::CntW-1:0]  scnt;
		logic [ags_pkg::CntW-1:0]  rcnt;
		logic [ags_pkg::AlgW-1:0]  alg;
		logic                      last;
	} step_t;

	// Works out the schedule of each accepted request and checks the steps that come out.
	class schedule_scoreboard;
		step_t                    expected_steps[$];
		logic [ags_pkg::CfgW-1:0] long_lim  = ags_pkg::LongReset;
		logic [ags_pkg::CfgW-1:0] short_lim = ags_pkg::ShortReset;
		int                       errors    = 0;

		function void set_limit(logic [ags_pkg::CfgIdxW-1:0] idx,
			logic [ags_pkg::CfgW-1:0] val);
			if (idx == ags_pkg::CfgLong) begin
				long_lim = val;
			end else begin
				short_lim = val;
			end
		endfunction

		function void add_step(longint unsigned dst, longint unsigned src,
			longint unsigned sc, longint unsigned rc, logic [ags_pkg::AlgW-1:0] alg);
			step_t s;
			s.dest   = dst[ags_pkg::RankW-1:0];
			s.source = src[ags_pkg::RankW-1:0];
			s.scnt   = sc[ags_pkg::CntW-1:0];
			s.rcnt   = rc[ags_pkg::CntW-1:0];
			s.alg    = alg;
			s.last   = 1'b0;
			expected_steps.push_back(s);
		endfunction

		// Returns the number of steps that the request produces.
		function int plan_schedule(logic [ags_pkg::RankW-1:0] rk,
			logic [ags_pkg::SizeW-1:0] gs, logic [ags_pkg::ElemW-1:0] se,
			logic [ags_pkg::ElemW-1:0] re, logic [ags_pkg::EbW-1:0] eb);
			longint unsigned rank, p, r, total, mask, cur, dst, droot, pof2, rem;
			int n;
			int i;
			rank = 64'(rk);
			p    = 64'(gs);
			r    = 64'(re);
			n    = 0;
			if (se == 0 || rank >= p || p > ags_pkg::MaxRanks) begin
				return 0;
			end
			total = r * p * 64'(eb);
			if (total < long_lim && (p & (p - 1)) == 0) begin
				// Recursive doubling: exchange with the partner across each mask bit.
				mask = 1;
				i    = 0;
				cur  = r;
				while (mask < p) begin
					dst   = rank ^ mask;
					droot = (dst >> i) << i;
					if (dst < p) begin
						add_step(dst, dst, cur, (p - droot) * r, ags_pkg::AlgRd);
						n++;
						cur += mask * r;
					end
					mask <<= 1;
					i++;
				end
			end else if (total < short_lim) begin
				// Bruck: doubling steps and then one step for the remainder.
				pof2 = 1;
				cur  = r;
				while (pof2 <= p / 2) begin
					add_step((rank + p - pof2) % p, (rank + pof2) % p, cur, cur,
						ags_pkg::AlgBruck);
					n++;
					cur  *= 2;
					pof2 *= 2;
				end
				rem = p - pof2;
				if (rem != 0) begin
					add_step((rank + p - pof2) % p, (rank + pof2) % p, rem * r, rem * r,
						ags_pkg::AlgBruck);
					n++;
				end
			end else begin
				// Ring: pass one block to the right neighbor per step.
				for (i = 1; i < p; i++) begin
					add_step((rank + 1) % p, (p + rank - 1) % p, r, r, ags_pkg::AlgRing);
					n++;
				end
			end
			if (n > 0) begin
				expected_steps[expected_steps.size() - 1].last = 1'b1;
			end
			return n;
		endfunction

		function void compare_field(string name, longint unsigned exp_v,
			longint unsigned act_v);
			if (exp_v != act_v) begin
				$error("%s: expected %0d, got %0d", name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_step(step_t got);
			step_t want;
			if (expected_steps.size() == 0) begin
				$error("step transfer with no step expected: dest_rank %0d source_rank %0d",
					got.dest, got.source);
				errors++;
				return;
			end
			want = expected_steps.pop_front();
			compare_field("dest_rank", want.dest, got.dest);
			compare_field("source_rank", want.source, got.source);
			compare_field("step_send_elems", want.scnt, got.scnt);
			compare_field("step_recv_elems", want.rcnt, got.rcnt);
			compare_field("algorithm", want.alg, got.alg);
			compare_field("last_step", want.last, got.last);
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_we;
	logic [ags_pkg::CfgIdxW-1:0]   cfg_index;
	logic [ags_pkg::CfgW-1:0]      cfg_data;
	logic                          in_valid;
	logic                          in_stall;
	logic [ags_pkg::RankW-1:0]     own_rank;
	logic [ags_pkg::SizeW-1:0]     group_size;
	logic [ags_pkg::ElemW-1:0]     send_elems;
	logic [ags_pkg::ElemW-1:0]     recv_elems;
	logic [ags_pkg::EbW-1:0]       elem_bytes;
	logic                          out_valid;
	logic                          out_stall;
	logic [ags_pkg::RankW-1:0]     dest_rank;
	logic [ags_pkg::RankW-1:0]     source_rank;
	logic [ags_pkg::CntW-1:0]      step_send_elems;
	logic [ags_pkg::CntW-1:0]      step_recv_elems;
	logic [ags_pkg::AlgW-1:0]      algorithm;
	logic                          last_step;

	schedule_scoreboard sb = new;
	int                 hold_len = 0;
	int                 idle_cycles = 0;

	allgather_schedule_generator_core u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.own_rank        (own_rank),
		.group_size      (group_size),
		.send_elems      (send_elems),
		.recv_elems      (recv_elems),
		.elem_bytes      (elem_bytes),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.dest_rank       (dest_rank),
		.source_rank     (source_rank),
		.step_send_elems (step_send_elems),
		.step_recv_elems (step_recv_elems),
		.algorithm       (algorithm),
		.last_step       (last_step)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Check every step transfer against the oldest expected step.
	always @(posedge clk) begin
		step_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.dest   = dest_rank;
			got.source = source_rank;
			got.scnt   = step_send_elems;
			got.rcnt   = step_recv_elems;
			got.alg    = algorithm;
			got.last   = last_step;
			sb.check_step(got);
		end
	end

	// End the run when no transfer happens on either side for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WatchdogLimit) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// The output side stalls in stretches of changing style, or holds off entirely on request.
	initial begin
		int mode;
		int run_len;
		int k;
		out_stall = 1'b0;
		forever begin
			mode    = $urandom_range(0, 3);
			run_len = $urandom_range(5, 60);
			for (k = 0; k < run_len; k++) begin
				@(negedge clk);
				if (hold_len > 0) begin
					out_stall <= 1'b1;
					hold_len--;
				end else begin
					case (mode)
						0: out_stall <= 1'b0;
						1: out_stall <= ($urandom_range(0, 2) == 0);
						2: out_stall <= (k % 4 == 3);
						default: out_stall <= ($urandom_range(0, 3) != 0);
					endcase
				end
			end
		end
	end

	// Offer one request and wait for its transfer; returns the number of steps it causes.
	task automatic send_request(input logic [ags_pkg::RankW-1:0] rk,
		input logic [ags_pkg::SizeW-1:0] gs, input logic [ags_pkg::ElemW-1:0] se,
		input logic [ags_pkg::ElemW-1:0] re, input logic [ags_pkg::EbW-1:0] eb,
		output int steps);
		@(negedge clk);
		in_valid   <= 1'b1;
		own_rank   <= rk;
		group_size <= gs;
		send_elems <= se;
		recv_elems <= re;
		elem_bytes <= eb;
		do begin
			@(posedge clk);
		end while (in_stall);
		steps = sb.plan_schedule(rk, gs, se, re, eb);
	endtask

	task automatic pause_input(input int cycles);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Let every expected step come out, then give the block time to settle.
	task automatic wait_for_drain();
		pause_input(1);
		while (sb.expected_steps.size() != 0) @(posedge clk);
		repeat (IdlePad) @(posedge clk);
	endtask

	task automatic write_limit(input logic [ags_pkg::CfgIdxW-1:0] idx,
		input logic [ags_pkg::CfgW-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		sb.set_limit(idx, val);
	endtask

	// Mostly well-formed requests with random content; the rest is unconstrained noise.
	task automatic send_random(output int steps);
		logic [ags_pkg::RankW-1:0] rk;
		logic [ags_pkg::SizeW-1:0] gs;
		logic [ags_pkg::ElemW-1:0] se;
		logic [ags_pkg::ElemW-1:0] re;
		logic [ags_pkg::EbW-1:0]   eb;
		int                        pick;
		pick = $urandom_range(0, 99);
		if (pick < 75) begin
			if (pick < 35) begin
				gs = ags_pkg::SizeW'($urandom_range(1, 16));
			end else if (pick < 55) begin
				gs = ags_pkg::SizeW'($urandom_range(17, 64));
			end else begin
				gs = 7'd1 << $urandom_range(0, 6);
			end
			rk = ags_pkg::RankW'($urandom_range(0, gs - 1));
			if ($urandom_range(0, 3) == 0) begin
				se = ags_pkg::ElemW'($urandom_range(1, 1048575));
			end else begin
				se = ags_pkg::ElemW'($urandom_range(1, 64));
			end
			case ($urandom_range(0, 4))
				0, 1: re = ags_pkg::ElemW'($urandom_range(0, 255));
				2, 3: re = ags_pkg::ElemW'($urandom_range(0, 4095));
				default: re = ags_pkg::ElemW'($urandom_range(0, 1048575));
			endcase
			if ($urandom_range(0, 7) == 0) begin
				eb = ags_pkg::EbW'($urandom_range(0, 511));
			end else begin
				eb = ags_pkg::EbW'($urandom_range(1, 256));
			end
		end else begin
			rk = ags_pkg::RankW'($urandom_range(0, 63));
			gs = ags_pkg::SizeW'($urandom_range(0, 127));
			if ($urandom_range(0, 3) == 0) begin
				se = '0;
			end else begin
				se = ags_pkg::ElemW'($urandom_range(0, 1048575));
			end
			re = ags_pkg::ElemW'($urandom_range(0, 1048575));
			eb = ags_pkg::EbW'($urandom_range(0, 511));
		end
		send_request(rk, gs, se, re, eb, steps);
	endtask

	initial begin
		logic [63:0]              wide;
		logic [ags_pkg::CfgW-1:0] long_val;
		logic [ags_pkg::CfgW-1:0] short_val;
		int                       steps;
		int                       produced;
		int                       phase;
		int                       burst;
		int                       gap;
		int                       k;
		bit                       held_off;

		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = ags_pkg::CfgLong;
		cfg_data   = '0;
		in_valid   = 1'b0;
		own_rank   = '0;
		group_size = '0;
		send_elems = '0;
		recv_elems = '0;
		elem_bytes = '0;
		held_off   = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed requests under the reset limits.
		send_request(6'd3, 7'd8, 20'd0, 20'd5, 9'd4, steps);              // zero send count
		send_request(6'd5, 7'd3, 20'd1, 20'd5, 9'd4, steps);              // rank beyond group
		send_request(6'd0, 7'd0, 20'd1, 20'd5, 9'd4, steps);              // empty group
		send_request(6'd0, 7'd65, 20'd1, 20'd5, 9'd4, steps);             // group too large
		send_request(6'd63, 7'd127, 20'd1048575, 20'd1048575, 9'd511, steps);
		send_request(6'd0, 7'd1, 20'd7, 20'd5, 9'd4, steps);              // lone rank
		send_request(6'd63, 7'd64, 20'd1, 20'd1, 9'd1, steps);            // recursive doubling
		send_request(6'd5, 7'd8, 20'd2, 20'd3, 9'd4, steps);
		send_request(6'd1, 7'd2, 20'd1048575, 20'd100, 9'd8, steps);
		send_request(6'd2, 7'd6, 20'd9, 20'd10, 9'd8, steps);             // Bruck with remainder
		send_request(6'd4, 7'd5, 20'd3, 20'd7, 9'd2, steps);
		send_request(6'd62, 7'd63, 20'd1, 20'd40, 9'd1, steps);
		send_request(6'd2, 7'd3, 20'd1, 20'd0, 9'd3, steps);              // nothing to receive
		send_request(6'd10, 7'd12, 20'd4, 20'd1048575, 9'd0, steps);      // zero element size
		send_request(6'd0, 7'd64, 20'd1, 20'd1048575, 9'd256, steps);     // ring, largest counts
		send_request(6'd6, 7'd7, 20'd1, 20'd1048575, 9'd511, steps);
		send_request(6'd17, 7'd64, 20'd1, 20'd8192, 9'd1, steps);         // total at long limit
		send_request(6'd33, 7'd64, 20'd1, 20'd8191, 9'd1, steps);         // just below it
		send_request(6'd4, 7'd5, 20'd1, 20'd16384, 9'd1, steps);          // total at short limit
		send_request(6'd3, 7'd5, 20'd1, 20'd16383, 9'd1, steps);          // just below it
		send_request(6'd1, 7'd32, 20'd1, 20'd1048575, 9'd300, steps);

		// Random phases, each under its own pair of limits.
		produced = 0;
		for (phase = 0; phase < NumPhases; phase++) begin
			wait_for_drain();
			case (phase)
				0: begin
					long_val  = ags_pkg::LongReset;
					short_val = ags_pkg::ShortReset;
				end
				1: begin
					long_val  = '0;
					short_val = '0;
				end
				2: begin
					long_val  = '1;
					short_val = 35'd17179869184;
				end
				3: begin
					long_val  = '0;
					short_val = '1;
				end
				4: begin
					long_val  = ags_pkg::CfgW'($urandom_range(0, 1 << 22));
					short_val = ags_pkg::CfgW'($urandom_range(0, 1 << 20));
				end
				default: begin
					wide      = {$urandom, $urandom};
					long_val  = wide[ags_pkg::CfgW-1:0];
					short_val = ags_pkg::CfgW'($urandom_range(0, 1 << 24));
				end
			endcase
			if (phase > 0) begin
				write_limit(ags_pkg::CfgLong, long_val);
				write_limit(ags_pkg::CfgShort, short_val);
			end
			while (produced < ItemTarget * (phase + 1) / NumPhases) begin
				burst = $urandom_range(1, 12);
				for (k = 0; k < burst && produced < ItemTarget * (phase + 1) / NumPhases;
					k++) begin
					send_random(steps);
					produced++;
					// Early in the ring phase the output holds off while requests keep coming.
					if (phase == 1 && !held_off && steps > 0) begin
						hold_len = HoldCycles;
						held_off = 1'b1;
					end
				end
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
				if (gap > 0) begin
					pause_input(gap);
				end
			end
		end

		wait_for_drain();
		if (sb.errors == 0 && sb.expected_steps.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
